// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stencil block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define VLS3_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VLS3_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define VLS3_ASSERT(lbl, clk, rstn, prop, msg)
`define VLS3_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: hw/rtl/vls3_pkg.sv
// ----------------------------------------------------------------------------
// vls3_pkg
// Types and constants shared by the 3D vector Laplacian stencil.
// ----------------------------------------------------------------------------
package vls3_pkg;

    localparam int MAG_W   = 16;
    localparam int CELL_W  = 3 * MAG_W;
    localparam int COEF_W  = 32;
    localparam int DIFF_W  = MAG_W + 1;
    localparam int PROD_W  = DIFF_W + COEF_W + 1;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PAIR_W + 2;
    localparam int FIELD_W = 52;
    localparam int OUT_TDATA_W = 160;
    localparam int CFG_IDX_W = 3;

    // window taps, relative to the emitted cell
    localparam int N_TAPS   = 7;
    localparam int TAP_CTR  = 0;
    localparam int TAP_ZM   = 1;
    localparam int TAP_ZP   = 2;
    localparam int TAP_YM   = 3;
    localparam int TAP_YP   = 4;
    localparam int TAP_XM   = 5;
    localparam int TAP_XP   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_X = 3'd0,
        CFG_COEF_Y = 3'd1,
        CFG_COEF_Z = 3'd2,
        CFG_SIZE_X = 3'd3,
        CFG_SIZE_Y = 3'd4,
        CFG_SIZE_Z = 3'd5
    } cfg_reg_e;

    // which neighbors of a cell lie on the grid
    typedef struct packed {
        logic zm;
        logic zp;
        logic ym;
        logic yp;
        logic xm;
        logic xp;
    } nbr_flags_t;

    localparam int FLAGS_W = $bits(nbr_flags_t);

    typedef struct packed {
        logic grid_full;
        logic job_push;
    } front_status_t;

endpackage

// File: hw/rtl/vls3_ram.sv
// ----------------------------------------------------------------------------
// vls3_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vls3_ram #(
    parameter int W     = 48,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/vls3_front.sv
// ----------------------------------------------------------------------------
// vls3_front
// Accepts items, writes cells into the window and issues emission jobs.
// ----------------------------------------------------------------------------
module vls3_front import vls3_pkg::*; #(
    parameter int MAX_PLANES = 1024,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int AW         = 14
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              clr,
    input  logic [$clog2(MAX_PLANES+1)-1:0]   nx,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     ny,
    input  logic [$clog2(MAX_COLS+1)-1:0]     nz,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [CELL_W-1:0]                 s_tdata,
    input  logic                              s_tuser,
    input  logic                              q_full,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [CELL_W-1:0]                 wr_data,
    output logic [AW-1:0]                     job_addr,
    output nbr_flags_t                        job_flags,
    output logic                              job_last,
    output front_status_t                     status
);

    localparam int XW = $clog2(MAX_PLANES + 1);
    localparam int YW = $clog2(MAX_ROWS + 1);
    localparam int ZW = $clog2(MAX_COLS + 1);
    localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int JW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int KW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [AW-1:0] r_addr_reg, e_addr_reg;
    logic [IW-1:0] ri_reg, ei_reg;
    logic [JW-1:0] rj_reg, ej_reg;
    logic [KW-1:0] rk_reg, ek_reg;
    logic          full_reg;

    logic accept, push, drain, emit;
    logic r_kend, r_jend, r_iend, e_kend, e_jend, e_iend;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && !s_tuser && !full_reg;
    assign drain    = accept && s_tuser && full_reg;
    assign emit     = (push && (ri_reg != '0)) || drain;

    assign r_kend = (ZW'(rk_reg) == nz - ZW'(1));
    assign r_jend = (YW'(rj_reg) == ny - YW'(1));
    assign r_iend = (XW'(ri_reg) == nx - XW'(1));
    assign e_kend = (ZW'(ek_reg) == nz - ZW'(1));
    assign e_jend = (YW'(ej_reg) == ny - YW'(1));
    assign e_iend = (XW'(ei_reg) == nx - XW'(1));

    assign wr_en   = push;
    assign wr_addr = r_addr_reg;
    assign wr_data = s_tdata;

    assign job_addr     = e_addr_reg;
    assign job_flags.zm = (ek_reg != '0);
    assign job_flags.zp = !e_kend;
    assign job_flags.ym = (ej_reg != '0);
    assign job_flags.yp = !e_jend;
    assign job_flags.xm = (ei_reg != '0);
    assign job_flags.xp = !e_iend;
    assign job_last     = e_kend && e_jend && e_iend;

    assign status.grid_full = full_reg;
    assign status.job_push  = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn || clr || (emit && job_last)) begin
            r_addr_reg <= '0;
            e_addr_reg <= '0;
            ri_reg     <= '0;
            rj_reg     <= '0;
            rk_reg     <= '0;
            ei_reg     <= '0;
            ej_reg     <= '0;
            ek_reg     <= '0;
            full_reg   <= 1'b0;
        end else begin
            if (push) begin
                r_addr_reg <= r_addr_reg + AW'(1);
                if (r_kend && r_jend && r_iend) begin
                    full_reg <= 1'b1;
                end
                if (r_kend) begin
                    rk_reg <= '0;
                    if (r_jend) begin
                        rj_reg <= '0;
                        ri_reg <= ri_reg + IW'(1);
                    end else begin
                        rj_reg <= rj_reg + JW'(1);
                    end
                end else begin
                    rk_reg <= rk_reg + KW'(1);
                end
            end
            if (emit) begin
                e_addr_reg <= e_addr_reg + AW'(1);
                if (e_kend) begin
                    ek_reg <= '0;
                    if (e_jend) begin
                        ej_reg <= '0;
                        ei_reg <= ei_reg + IW'(1);
                    end else begin
                        ej_reg <= ej_reg + JW'(1);
                    end
                end else begin
                    ek_reg <= ek_reg + KW'(1);
                end
            end
        end
    end

endmodule

// File: hw/rtl/vls3_queue.sv
// ----------------------------------------------------------------------------
// vls3_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module vls3_queue #(
    parameter int W     = 21,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output logic         empty,
    output logic         full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign head_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/vls3_back.sv
// ----------------------------------------------------------------------------
// vls3_back
// Reads the seven window taps for a job and forms and sums the weighted differences.
// ----------------------------------------------------------------------------
module vls3_back import vls3_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int AW       = 14
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [COEF_W-1:0]                      coef_x,
    input  logic [COEF_W-1:0]                      coef_y,
    input  logic [COEF_W-1:0]                      coef_z,
    input  logic [$clog2(MAX_COLS+1)-1:0]          nz,
    input  logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0] nyz,
    input  logic                                   q_empty,
    input  logic [AW-1:0]                          q_addr,
    input  nbr_flags_t                             q_flags,
    input  logic                                   q_last,
    output logic                                   q_pop,
    output logic                                   rd_en,
    output logic [AW-1:0]                          rd_addr [N_TAPS],
    input  logic [CELL_W-1:0]                      rd_data [N_TAPS],
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [OUT_TDATA_W-1:0]                 m_tdata,
    output logic                                   m_tlast
);

    logic en;

    logic       p1_vld_reg, p2_vld_reg, p3_vld_reg, out_vld_reg;
    nbr_flags_t p1_flags_reg;
    logic       p1_last_reg, p2_last_reg, p3_last_reg, out_last_reg;

    logic signed [PROD_W-1:0] prod_next [3][N_TAPS-1];
    logic signed [PROD_W-1:0] prod_reg  [3][N_TAPS-1];
    logic signed [PAIR_W-1:0] pair_reg  [3][3];
    logic [FIELD_W-1:0]       field_reg [3];

    // whole pipeline stalls together when the output register is held
    assign en       = !out_vld_reg || m_tready;
    assign q_pop    = en && !q_empty;
    assign rd_en    = en;

    assign rd_addr[TAP_CTR] = q_addr;
    assign rd_addr[TAP_ZM]  = q_addr - AW'(1);
    assign rd_addr[TAP_ZP]  = q_addr + AW'(1);
    assign rd_addr[TAP_YM]  = q_addr - AW'(nz);
    assign rd_addr[TAP_YP]  = q_addr + AW'(nz);
    assign rd_addr[TAP_XM]  = q_addr - AW'(nyz);
    assign rd_addr[TAP_XP]  = q_addr + AW'(nyz);

    always_comb begin
        logic signed [MAG_W-1:0]  nb, ct;
        logic signed [DIFF_W-1:0] d;
        logic signed [COEF_W:0]   cf;
        logic                     on;
        for (int c = 0; c < 3; c++) begin
            for (int n = 1; n < N_TAPS; n++) begin
                nb = rd_data[n][c*MAG_W +: MAG_W];
                ct = rd_data[TAP_CTR][c*MAG_W +: MAG_W];
                d  = DIFF_W'(nb) - DIFF_W'(ct);
                case (n)
                    TAP_ZM: begin cf = {1'b0, coef_z}; on = p1_flags_reg.zm; end
                    TAP_ZP: begin cf = {1'b0, coef_z}; on = p1_flags_reg.zp; end
                    TAP_YM: begin cf = {1'b0, coef_y}; on = p1_flags_reg.ym; end
                    TAP_YP: begin cf = {1'b0, coef_y}; on = p1_flags_reg.yp; end
                    TAP_XM: begin cf = {1'b0, coef_x}; on = p1_flags_reg.xm; end
                    default: begin cf = {1'b0, coef_x}; on = p1_flags_reg.xp; end
                endcase
                prod_next[c][n-1] = on ? PROD_W'(d * cf) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg  <= q_pop;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            out_vld_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_flags_reg <= q_flags;
            p1_last_reg  <= q_last;
            p2_last_reg  <= p1_last_reg;
            p3_last_reg  <= p2_last_reg;
            out_last_reg <= p3_last_reg;
            prod_reg     <= prod_next;
            for (int c = 0; c < 3; c++) begin
                for (int p = 0; p < 3; p++) begin
                    pair_reg[c][p] <= PAIR_W'(prod_reg[c][2*p]) + PAIR_W'(prod_reg[c][2*p+1]);
                end
                field_reg[c] <= FIELD_W'(SUM_W'(pair_reg[c][0]) + SUM_W'(pair_reg[c][1])
                                         + SUM_W'(pair_reg[c][2]));
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_TDATA_W - 3*FIELD_W)'(0), field_reg[2], field_reg[1], field_reg[0]};

endmodule

// File: hw/rtl/vector_laplacian_stencil_3d.sv
// ----------------------------------------------------------------------------
// vector_laplacian_stencil_3d
// Streaming anisotropic seven-point Laplacian of a vector field on a 3D grid.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result per clock unless the queue
// is full or the output stalls: the front writes each pushed cell into a
// window held in seven identical RAM copies (one per stencil tap, each 48 bits
// wide and a power of two deep above two planes), so all six neighbors and the
// center are read in the same cycle. Jobs pass the queue, read, product, pair
// and field registers. The window needs no clearing pass; only written cells
// are ever used. A cell's result follows the push of the cell one plane later;
// drain items return the last plane once the grid is complete.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_laplacian_stencil_3d import vls3_pkg::*; #(
    parameter int MAX_PLANES = 1024,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CELL_W-1:0]      s_tdata,   // mag_x, mag_y, mag_z
    input  logic                   s_tuser,   // action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // field_x, field_y, field_z, zero pad
    output logic                   m_tlast,   // last_cell
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

    localparam int XW     = $clog2(MAX_PLANES + 1);
    localparam int YW     = $clog2(MAX_ROWS + 1);
    localparam int ZW     = $clog2(MAX_COLS + 1);
    localparam int YZW    = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int QDEPTH = 4;
    localparam int AW     = $clog2(2 * MAX_ROWS * MAX_COLS + QDEPTH + 3);
    localparam int JOB_W  = AW + FLAGS_W + 1;

    localparam int SX_W = 11;
    localparam int SY_W = 7;
    localparam int SZ_W = 7;

    // configuration
    logic [COEF_W-1:0] coef_x_reg, coef_y_reg, coef_z_reg;
    logic [XW-1:0]     nx_reg, nx_next;
    logic [YW-1:0]     ny_reg, ny_next;
    logic [ZW-1:0]     nz_reg, nz_next;
    logic [YZW-1:0]    nyz_reg;
    logic              size_clr;
    logic [SX_W-1:0]   sx;
    logic [SY_W-1:0]   sy;
    logic [SZ_W-1:0]   sz;

    assign cfg_ready = 1'b1;
    assign sx = cfg_data[SX_W-1:0];
    assign sy = cfg_data[SY_W-1:0];
    assign sz = cfg_data[SZ_W-1:0];

    always_comb begin
        nx_next  = nx_reg;
        ny_next  = ny_reg;
        nz_next  = nz_reg;
        size_clr = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIZE_X: begin
                    size_clr = 1'b1;
                    nx_next  = (sx == '0) ? XW'(1) :
                               (32'(sx) > MAX_PLANES) ? XW'(MAX_PLANES) : XW'(sx);
                end
                CFG_SIZE_Y: begin
                    size_clr = 1'b1;
                    ny_next  = (sy == '0) ? YW'(1) :
                               (32'(sy) > MAX_ROWS) ? YW'(MAX_ROWS) : YW'(sy);
                end
                CFG_SIZE_Z: begin
                    size_clr = 1'b1;
                    nz_next  = (sz == '0) ? ZW'(1) :
                               (32'(sz) > MAX_COLS) ? ZW'(MAX_COLS) : ZW'(sz);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_x_reg <= '0;
            coef_y_reg <= '0;
            coef_z_reg <= '0;
            nx_reg     <= XW'(1);
            ny_reg     <= YW'(1);
            nz_reg     <= ZW'(1);
            nyz_reg    <= YZW'(1);
        end else begin
            if (cfg_valid && cfg_index == CFG_COEF_X) coef_x_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_COEF_Y) coef_y_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_COEF_Z) coef_z_reg <= cfg_data;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            nz_reg  <= nz_next;
            nyz_reg <= YZW'(ny_next * nz_next);
        end
    end

    // front
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [AW-1:0]     job_addr;
    nbr_flags_t        job_flags;
    logic              job_last;
    front_status_t     front_st;
    logic              q_full, q_empty, q_pop;
    logic [JOB_W-1:0]  q_head;

    vls3_front #(
        .MAX_PLANES(MAX_PLANES),
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .AW        (AW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (size_clr),
        .nx       (nx_reg),
        .ny       (ny_reg),
        .nz       (nz_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .job_addr (job_addr),
        .job_flags(job_flags),
        .job_last (job_last),
        .status   (front_st)
    );

    vls3_queue #(
        .W    (JOB_W),
        .DEPTH(QDEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_st.job_push),
        .push_data({job_addr, job_flags, job_last}),
        .pop      (q_pop),
        .head_data(q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // window: one copy per tap, all written alike
    logic              rd_en;
    logic [AW-1:0]     rd_addr [N_TAPS];
    logic [CELL_W-1:0] rd_data [N_TAPS];

    for (genvar t = 0; t < N_TAPS; t++) begin : g_win
        vls3_ram #(
            .W    (CELL_W),
            .DEPTH(2 ** AW)
        ) u_ram (
            .aclk (aclk),
            .we   (wr_en),
            .waddr(wr_addr),
            .wdata(wr_data),
            .re   (rd_en),
            .raddr(rd_addr[t]),
            .rdata(rd_data[t])
        );
    end

    vls3_back #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .AW      (AW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef_x  (coef_x_reg),
        .coef_y  (coef_y_reg),
        .coef_z  (coef_z_reg),
        .nz      (nz_reg),
        .nyz     (nyz_reg),
        .q_empty (q_empty),
        .q_addr  (q_head[JOB_W-1 -: AW]),
        .q_flags (nbr_flags_t'(q_head[FLAGS_W:1])),
        .q_last  (q_head[0]),
        .q_pop   (q_pop),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    logic drain_early;
    assign drain_early = s_tvalid && s_tready && s_tuser && !front_st.grid_full;

    `VLS3_NEVER(a_queue_overflow, aclk, aresetn, front_st.job_push && q_full, "job queue overflow")
    `VLS3_NEVER(a_queue_underflow, aclk, aresetn, q_pop && q_empty, "job queue underflow")
    `VLS3_ASSERT(a_drain_gated, aclk, aresetn, drain_early |-> !front_st.job_push, "early drain")

endmodule

// File: verif/vls3_checker.sv
// ----------------------------------------------------------------------------
// vls3_checker
// Watches the cell, result and register channels of the stencil block.
// Predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module vls3_checker import vls3_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [CELL_W-1:0]      s_tdata,   // mag_x, mag_y, mag_z
    input  logic                   s_tuser,   // action
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // field_x, field_y, field_z, zero pad
    input  logic                   m_tlast,   // last_cell
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]      cfg_data,
    output int                     errors,
    output int                     pending
);
    localparam int PLANES = 1024;
    localparam int ROWS   = 64;
    localparam int COLS   = 64;
    localparam int DEPTH  = 2 * ROWS * COLS + 1;

    typedef struct {
        logic [FIELD_W-1:0] fx;
        logic [FIELD_W-1:0] fy;
        logic [FIELD_W-1:0] fz;
        logic               last;
    } laplacian_t;

    laplacian_t       laplacian_q[$];
    shortint          cell_mem[DEPTH][3];
    int unsigned      n_received;
    int unsigned      n_emitted;
    logic [COEF_W-1:0] kx, ky, kz;
    logic [10:0]      raw_sx;
    logic [6:0]       raw_sy, raw_sz;

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void add_coupling(ref longint acc[3], input int unsigned nb,
                                         input int unsigned ctr, input logic [COEF_W-1:0] k);
        for (int c = 0; c < 3; c++)
            acc[c] += longint'(int'(cell_mem[nb % DEPTH][c]) - int'(cell_mem[ctr % DEPTH][c]))
                      * longint'({32'd0, k});
    endfunction

    // compute the oldest outstanding cell's Laplacian and advance
    function automatic void emit_laplacian(int unsigned nx, int unsigned ny, int unsigned nz);
        int unsigned e, nyz, total, i, j, k;
        longint acc[3];
        laplacian_t r;
        e = n_emitted;
        nyz = ny * nz;
        total = nx * nyz;
        i = e / nyz;
        j = (e / nz) % ny;
        k = e % nz;
        acc = '{0, 0, 0};
        if (k > 0) add_coupling(acc, e - 1, e, kz);
        if (j > 0) add_coupling(acc, e - nz, e, ky);
        if (i > 0) add_coupling(acc, e - nyz, e, kx);
        if (i + 1 < nx) add_coupling(acc, e + nyz, e, kx);
        if (j + 1 < ny) add_coupling(acc, e + nz, e, ky);
        if (k + 1 < nz) add_coupling(acc, e + 1, e, kz);
        r.fx = acc[0][FIELD_W-1:0];
        r.fy = acc[1][FIELD_W-1:0];
        r.fz = acc[2][FIELD_W-1:0];
        r.last = (e + 1 == total);
        laplacian_q.push_back(r);
        n_emitted = e + 1;
        if (n_emitted >= total) begin
            n_emitted = 0;
            n_received = 0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        int unsigned nx, ny, nz, total;
        laplacian_t w;
        if (!aresetn) begin
            laplacian_q.delete();
            n_received = 0;
            n_emitted = 0;
            kx = '0; ky = '0; kz = '0;
            raw_sx = 11'd1; raw_sy = 7'd1; raw_sz = 7'd1;
        end else begin
            // results first: an item taken at this edge cannot have produced one yet
            if (m_tvalid && m_tready) begin
                if (laplacian_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[FIELD_W-1:0], 0);
                end else begin
                    w = laplacian_q.pop_front();
                    if (m_tdata[FIELD_W-1:0] !== w.fx)
                        report_mismatch("field_x", m_tdata[FIELD_W-1:0], w.fx);
                    if (m_tdata[2*FIELD_W-1:FIELD_W] !== w.fy)
                        report_mismatch("field_y", m_tdata[2*FIELD_W-1:FIELD_W], w.fy);
                    if (m_tdata[3*FIELD_W-1:2*FIELD_W] !== w.fz)
                        report_mismatch("field_z", m_tdata[3*FIELD_W-1:2*FIELD_W], w.fz);
                    if (m_tlast !== w.last)
                        report_mismatch("last_cell", m_tlast, w.last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_e'(cfg_index))
                    CFG_COEF_X: kx = cfg_data;
                    CFG_COEF_Y: ky = cfg_data;
                    CFG_COEF_Z: kz = cfg_data;
                    CFG_SIZE_X: begin raw_sx = cfg_data[10:0]; n_received = 0; n_emitted = 0; end
                    CFG_SIZE_Y: begin raw_sy = cfg_data[6:0]; n_received = 0; n_emitted = 0; end
                    CFG_SIZE_Z: begin raw_sz = cfg_data[6:0]; n_received = 0; n_emitted = 0; end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                nx = clamp(raw_sx, PLANES);
                ny = clamp(raw_sy, ROWS);
                nz = clamp(raw_sz, COLS);
                total = nx * ny * nz;
                if (!s_tuser) begin
                    if (n_received < total) begin
                        cell_mem[n_received % DEPTH][0] = s_tdata[15:0];
                        cell_mem[n_received % DEPTH][1] = s_tdata[31:16];
                        cell_mem[n_received % DEPTH][2] = s_tdata[47:32];
                        n_received++;
                        if (n_received > n_emitted + ny * nz)
                            emit_laplacian(nx, ny, nz);
                    end
                end else if (n_received >= total && n_emitted < total) begin
                    emit_laplacian(nx, ny, nz);
                end
            end
        end
        pending = laplacian_q.size();
    end

endmodule

// File: verif/tb_vector_laplacian_stencil_3d.sv
// ----------------------------------------------------------------------------
// tb_vector_laplacian_stencil_3d
// Streams grids of vector cells through the stencil block under random
// stalls, with directed extremes first, and checks each result via vls3_checker.
// ----------------------------------------------------------------------------
module tb_vector_laplacian_stencil_3d import vls3_pkg::*; ();

    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE      = 24;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [CELL_W-1:0]      s_tdata;   // mag_x, mag_y, mag_z
    logic                   s_tuser;   // action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // field_x, field_y, field_z, zero pad
    logic                   m_tlast;   // last_cell
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COEF_W-1:0]      cfg_data;
    int                     errors;
    int                     pending;

    int  send_idle;
    int  recv_idle;
    int  hold_cycles;
    int  cycles;
    bit  need_size;

    vector_laplacian_stencil_3d uut (.*);
    vls3_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_vector_laplacian_stencil_3d failed");
            $finish;
        end
    end

    // receiver: random backpressure plus requested long holds
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(cfg_reg_e idx, logic [COEF_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(bit drain, logic [CELL_W-1:0] item_data);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= drain;
        s_tdata <= item_data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold until every result has come, then let the pipeline settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_mag();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // one grid: push all cells, then drain, with some noise and abandonment
    task automatic run_grid(int sx, int sy, int sz, int raw_x, int raw_y, int raw_z);
        int total, nyz, stop;
        wait_drained();
        write_reg(CFG_COEF_X, rand_coef());
        write_reg(CFG_COEF_Y, rand_coef());
        write_reg(CFG_COEF_Z, rand_coef());
        if (need_size || $urandom_range(9) < 8) begin
            write_reg(CFG_SIZE_X, raw_x);
            write_reg(CFG_SIZE_Y, raw_y);
            write_reg(CFG_SIZE_Z, raw_z);
        end
        need_size = 1'b0;
        nyz = sy * sz;
        total = sx * nyz;
        stop = total;
        if ($urandom_range(11) == 0) begin
            stop = $urandom_range(total - 1);
            need_size = 1'b1;
        end
        for (int n = 0; n < stop; n++) begin
            if ($urandom_range(29) == 0) send_item(1'b1, 48'($urandom));
            send_item(1'b0, {rand_mag(), rand_mag(), rand_mag()});
        end
        if (need_size) return;
        if ($urandom_range(4) == 0) send_item(1'b0, 48'($urandom));
        for (int n = 0; n < nyz; n++) send_item(1'b1, 48'($urandom));
        if ($urandom_range(4) == 0) send_item(1'b1, 48'($urandom));
    endtask

    initial begin
        int sx, sy, sz;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COEF_X;
        cfg_data = '0;
        cycles = 0;
        hold_cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        need_size = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // reset grid is one cell: push, drain, then a drain with nothing left
        send_item(1'b0, 48'h8000_7fff_8000);
        send_item(1'b1, '0);
        send_item(1'b1, '0);
        wait_drained();
        write_reg(CFG_COEF_X, '1);
        write_reg(CFG_COEF_Y, '1);
        write_reg(CFG_COEF_Z, '1);
        write_reg(CFG_SIZE_X, 2);
        write_reg(CFG_SIZE_Y, 2);
        write_reg(CFG_SIZE_Z, 2);
        send_item(1'b1, '0);
        for (int n = 0; n < 8; n++)
            send_item(1'b0, n[0] ? 48'h8000_7fff_8000 : 48'h7fff_8000_7fff);
        send_item(1'b0, 48'hffff_ffff_ffff);
        for (int n = 0; n < 5; n++) send_item(1'b1, '0);
        // overlarge x with zero y and z: a long line of one-cell planes, abandoned part way
        wait_drained();
        write_reg(CFG_SIZE_X, 2047);
        write_reg(CFG_SIZE_Y, 0);
        write_reg(CFG_SIZE_Z, 0);
        for (int n = 0; n < 160; n++)
            send_item(1'b0, {rand_mag(), rand_mag(), rand_mag()});
        need_size = 1'b1;
        // out-of-range sizes: zero acts as one, overlarge acts as the maximum
        run_grid(1, 64, 1, 0, 127, 1);
        run_grid(2, 1, 64, 2, 1, 127);
        run_grid(2, 64, 2, 2, 64, 2);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 14 : (phase == 1) ? 60 : 0;
            recv_idle = (phase == 0) ? 60 : (phase == 1) ? 14 : 0;
            if (phase == 2) begin
                // stall the output long enough for the block to back up
                wait_drained();
                hold_cycles = 400;
                run_grid(6, 4, 5, 6, 4, 5);
            end
            for (int g = 0; g < 4; g++) begin
                sx = $urandom_range(1, 6);
                sy = $urandom_range(1, 4);
                sz = $urandom_range(1, 5);
                run_grid(sx, sy, sz, sx, sy, sz);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("tb_vector_laplacian_stencil_3d passed");
        else
            $display("tb_vector_laplacian_stencil_3d failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/vls3_pkg.sv
hw/rtl/vls3_ram.sv
hw/rtl/vls3_front.sv
hw/rtl/vls3_queue.sv
hw/rtl/vls3_back.sv
hw/rtl/vector_laplacian_stencil_3d.sv
verif/vls3_checker.sv
verif/tb_vector_laplacian_stencil_3d.sv
